// ----- rtl/core/bgfs_pkg.sv -----
// Shared types and constants for the battery gauge fallback/slew block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package bgfs_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INPUT_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARGE_LIMIT = 1'b1;

   localparam logic [7:0] INPUT_LIMIT_RESET  = 8'h03;
   localparam logic [7:0] CHARGE_LIMIT_RESET = 8'h0A;

   localparam logic [6:0]  PCT_MAX     = 7'd100;
   localparam int          CHG_BIT     = 5;
   localparam int          MV_W        = 14;
   localparam logic [13:0] MV_FULL     = 14'd4150;
   localparam logic [13:0] MV_EMPTY    = 14'd3300;
   // (mv - 3300) * 10 / 85 == (mv - 3300) * 2 / 17; 1/17 taken as 3856 / 2^16,
   // exact for every numerator below 4096 (ours tops out at 1700)
   localparam int          SPAN_W      = 10;
   localparam int          NUM_W       = SPAN_W + 1;
   localparam int          RECIP_W     = 12;
   localparam logic [11:0] RECIP_17    = 12'd3856;
   localparam int          RECIP_SHIFT = 16;
   localparam int          PROD_W      = NUM_W + RECIP_W;

   typedef struct packed {
      logic [7:0] input_limit_read;
      logic       input_limit_ok;
      logic [7:0] charge_limit_read;
      logic       charge_limit_ok;
      logic [7:0] gauge_byte;
      logic       gauge_ok;
      logic [7:0] status_byte;
      logic       status_ok;
      logic [7:0] volt_high;
      logic [7:0] volt_low;
      logic       volt_ok;
   } req_type;

   typedef struct packed {
      logic       rewrite_input_limit;
      logic       rewrite_charge_limit;
      logic       show;
      logic [6:0] battery_percent;
      logic       charging;
   } rsp_type;

   typedef struct packed {
      logic [7:0] input_limit_code;
      logic [7:0] charge_limit_code;
   } csr_type;

   typedef struct packed {
      logic       primed;
      logic [6:0] level;
   } level_state_type;

endpackage

// ----- rtl/core/bgfs_csr.sv -----
// Configuration registers: expected input-limit and charge-limit codes.
// Depends on bgfs_pkg.
`timescale 1ns / 1ps

module bgfs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [bgfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                        csr_wdata,
   output bgfs_pkg::csr_type                 cfg
);
   import bgfs_pkg::*;

   csr_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_INPUT_LIMIT:  cfg_in.input_limit_code  = csr_wdata;
            CSR_CHARGE_LIMIT: cfg_in.charge_limit_code = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_limit_code  <= INPUT_LIMIT_RESET;
         cfg_ff.charge_limit_code <= CHARGE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/bgfs_calc.sv -----
// Per-tick evaluation: rewrite requests, voltage fallback and slew-limited level.
// Holds the smoothed level state. Depends on bgfs_pkg.
`timescale 1ns / 1ps

module bgfs_calc (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  bgfs_pkg::req_type         req,
   input  bgfs_pkg::csr_type         cfg,
   output bgfs_pkg::rsp_type         rsp,
   output bgfs_pkg::level_state_type stat
);
   import bgfs_pkg::*;

   level_state_type lvl_ff, lvl_in;

   logic [6:0]         gauge_pct;
   logic               use_fallback;
   logic [MV_W-1:0]    mv;
   logic [MV_W-1:0]    mv_span;
   logic [NUM_W-1:0]   num;
   logic [PROD_W-1:0]  prod;
   logic [6:0]         target;
   logic [6:0]         next_level;
   logic [6:0]         pct_sel;
   logic               show;

   always_comb begin
      gauge_pct    = req.gauge_byte[6:0];
      use_fallback = req.gauge_ok && req.volt_ok
                     && ((gauge_pct == 7'd0) || (gauge_pct > PCT_MAX));

      mv      = {req.volt_high[5:0], req.volt_low};
      mv_span = mv - MV_EMPTY;
      num     = {mv_span[SPAN_W-1:0], 1'b0};
      prod    = PROD_W'(num) * PROD_W'(RECIP_17);

      if (mv > MV_FULL)       target = PCT_MAX;
      else if (mv < MV_EMPTY) target = 7'd0;
      else                    target = prod[RECIP_SHIFT +: 7];

      // at most one step per tick once primed
      if (!lvl_ff.primed)           next_level = target;
      else if (target > lvl_ff.level) next_level = lvl_ff.level + 7'd1;
      else if (target < lvl_ff.level) next_level = lvl_ff.level - 7'd1;
      else                          next_level = lvl_ff.level;

      pct_sel = use_fallback ? next_level : gauge_pct;
      show    = req.gauge_ok && (pct_sel <= PCT_MAX);

      rsp.rewrite_input_limit  = req.input_limit_ok
                                 && (req.input_limit_read != cfg.input_limit_code);
      rsp.rewrite_charge_limit = req.charge_limit_ok
                                 && (req.charge_limit_read != cfg.charge_limit_code);
      rsp.show                 = show;
      rsp.battery_percent      = show ? pct_sel : 7'd0;
      rsp.charging             = req.status_ok && req.status_byte[CHG_BIT];

      lvl_in = lvl_ff;
      if (advance && use_fallback) begin
         lvl_in.primed = 1'b1;
         lvl_in.level  = next_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff <= '0;
      end else begin
         lvl_ff <= lvl_in;
      end
   end

   assign stat = lvl_ff;

endmodule

// ----- rtl/core/battery_gauge_fallback_slew.sv -----
// Battery gauge fallback/slew block, top level.
// Usage:
//   req_* carries one poll tick of register readings and read-success flags.
//   rsp_* returns one result beat per request beat: limit-rewrite requests,
//   show flag, percent to display and the charging bit.
//   csr_* writes the expected limit codes (index 0 input limit, 1 charge
//   limit); write only while no beat is in flight.
// Path: a request beat taken by the block loads into the input register, then
//   moves into the result register and is presented on rsp_*; rsp_stall can
//   keep it waiting in the input register.
// Throughput: one beat per cycle while rsp_stall is low; the evaluation is one
//   pass of short logic (one 11x12 constant multiply) between both registers.
// Stalls: while rsp_stall holds the result register, the input register still
//   takes a beat if it is empty; once both are full req_stall is raised.
// Reset: both registers empty, codes back to 3 and 10, smoothed level 0 and
//   not primed.
// Depends on bgfs_pkg, bgfs_csr and bgfs_calc.
`timescale 1ns / 1ps

module battery_gauge_fallback_slew (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_input_limit_read,
   input  logic                             req_input_limit_ok,
   input  logic [7:0]                       req_charge_limit_read,
   input  logic                             req_charge_limit_ok,
   input  logic [7:0]                       req_gauge_byte,
   input  logic                             req_gauge_ok,
   input  logic [7:0]                       req_status_byte,
   input  logic                             req_status_ok,
   input  logic [7:0]                       req_volt_high,
   input  logic [7:0]                       req_volt_low,
   input  logic                             req_volt_ok,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_rewrite_input_limit,
   output logic                             rsp_rewrite_charge_limit,
   output logic                             rsp_show,
   output logic [6:0]                       rsp_battery_percent,
   output logic                             rsp_charging,
   // configuration
   input  logic                             csr_write,
   input  logic [bgfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);
   import bgfs_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff;
   logic            out_load;
   logic            in_load;
   csr_type         cfg;
   rsp_type         calc_rsp;
   level_state_type lvl_stat;

   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_load || (in_valid_ff && !out_load);
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff.input_limit_read  <= req_input_limit_read;
         in_data_ff.input_limit_ok    <= req_input_limit_ok;
         in_data_ff.charge_limit_read <= req_charge_limit_read;
         in_data_ff.charge_limit_ok   <= req_charge_limit_ok;
         in_data_ff.gauge_byte        <= req_gauge_byte;
         in_data_ff.gauge_ok          <= req_gauge_ok;
         in_data_ff.status_byte       <= req_status_byte;
         in_data_ff.status_ok         <= req_status_ok;
         in_data_ff.volt_high         <= req_volt_high;
         in_data_ff.volt_low          <= req_volt_low;
         in_data_ff.volt_ok           <= req_volt_ok;
      end
      if (out_load) begin
         out_data_ff <= calc_rsp;
      end
   end

   bgfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state steps only when the beat moves into the result register
   bgfs_calc u_calc (
      .clock   (clock),
      .reset   (reset),
      .advance (out_load),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (calc_rsp),
      .stat    (lvl_stat)
   );

   assign rsp_valid                = out_valid_ff;
   assign rsp_rewrite_input_limit  = out_data_ff.rewrite_input_limit;
   assign rsp_rewrite_charge_limit = out_data_ff.rewrite_charge_limit;
   assign rsp_show                 = out_data_ff.show;
   assign rsp_battery_percent      = out_data_ff.battery_percent;
   assign rsp_charging             = out_data_ff.charging;

   // ---------------------------------------------------------------- checks
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_battery_percent <= PCT_MAX))
      else $error("displayed percent above full scale");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_show) |-> (rsp_battery_percent == 7'd0))
      else $error("percent not zero while hidden");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      lvl_stat.level <= PCT_MAX)
      else $error("smoothed level out of range");

   a_slew_step: assert property (@(posedge clock) disable iff (reset)
      $past(lvl_stat.primed) && lvl_stat.primed |->
         (lvl_stat.level == $past(lvl_stat.level))
         || (lvl_stat.level == $past(lvl_stat.level) + 7'd1)
         || (lvl_stat.level == $past(lvl_stat.level) - 7'd1))
      else $error("smoothed level moved more than one step");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken with both registers held");

endmodule
